>>> design/phd_pkg.sv
package phd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 10;

  localparam int FIELD_W   = 10;
  localparam int SQ_W      = 21;
  localparam int Q8_W      = 19;
  localparam int FRAC_BITS = 8;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int SQD_W  = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam int ROOT_W = (DIST_W + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [FIELD_W-1:0]   point_row;
    logic [FIELD_W-1:0]   point_col;
  } in_item_t;

  typedef struct packed {
    logic [SQ_W-1:0] squared_distance;
    logic [Q8_W-1:0] distance_q8;
    logic            empty_set;
    logic            overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OUT_RD,
    ST_OUT_LAT,
    ST_IN_RUN,
    ST_IN_DRAIN,
    ST_SQ_LOAD,
    ST_SQRT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic load;
    logic begin_run;
    logic outer_latch;
    logic inner_issue;
    logic finish_point;
    logic next_dir;
    logic sqrt_start;
    logic sqrt_step;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last_outer;
    logic last_inner;
    logic pipe_busy;
    logic dir;
    logic sqrt_last;
  } stat_t;

endpackage

>>> design/phd_ram.sv
module phd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/phd_ctrl.sv
module phd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  phd_pkg::action_t action,
  input  phd_pkg::stat_t   stat,
  output phd_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  import phd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && action == ACT_COMPUTE) begin
          state_next = stat.empty ? ST_SQ_LOAD : ST_OUT_RD;
        end
      end
      ST_OUT_RD:  state_next = ST_OUT_LAT;
      ST_OUT_LAT: state_next = ST_IN_RUN;
      ST_IN_RUN: begin
        if (stat.last_inner) begin
          state_next = ST_IN_DRAIN;
        end
      end
      ST_IN_DRAIN: begin
        if (!stat.pipe_busy) begin
          if (stat.last_outer && stat.dir) begin
            state_next = ST_SQ_LOAD;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_SQ_LOAD: state_next = ST_SQRT;
      ST_SQRT: begin
        if (stat.sqrt_last) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.load      = start && (action inside {ACT_LOAD_A, ACT_LOAD_B});
        cmd.begin_run = start && action == ACT_COMPUTE;
      end
      ST_OUT_LAT:  cmd.outer_latch = 1'b1;
      ST_IN_RUN:   cmd.inner_issue = 1'b1;
      ST_IN_DRAIN: begin
        cmd.finish_point = !stat.pipe_busy;
        cmd.next_dir     = !stat.pipe_busy && stat.last_outer && !stat.dir;
      end
      ST_SQ_LOAD:  cmd.sqrt_start = 1'b1;
      ST_SQRT:     cmd.sqrt_step  = 1'b1;
      ST_REPORT: begin
        cmd.report = 1'b1;
        done       = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> design/phd_dp.sv
module phd_dp (
  input  logic               clk,
  input  logic               rst,
  input  phd_pkg::in_item_t  item,
  input  phd_pkg::cmd_t      cmd,
  output phd_pkg::stat_t     stat,
  output phd_pkg::out_item_t result
);

  import phd_pkg::*;

  logic [CNT_W-1:0]  count_a;
  logic [CNT_W-1:0]  count_b;
  logic              dropped;
  logic              dir;
  logic              v1;
  logic              v2;
  logic [ADDR_W-1:0] i;
  logic [ADDR_W-1:0] j;
  logic [PT_W-1:0]   outer_pt;
  logic [SQD_W-1:0]  sq_r;
  logic [SQD_W-1:0]  sq_c;
  logic [DIST_W-1:0] best;
  logic [DIST_W-1:0] worst;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [STEP_W-1:0] step;

  logic              full_a;
  logic              full_b;
  logic              we_a;
  logic              we_b;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [PT_W-1:0]   wpt;
  logic [PT_W-1:0]   rd_a;
  logic [PT_W-1:0]   rd_b;
  logic [PT_W-1:0]   out_src;
  logic [PT_W-1:0]   in_pt;
  logic [CNT_W-1:0]  n1;
  logic [CNT_W-1:0]  n2;

  logic [COORD_BITS-1:0] or_r;
  logic [COORD_BITS-1:0] or_c;
  logic [COORD_BITS-1:0] ir_r;
  logic [COORD_BITS-1:0] ir_c;
  logic [COORD_BITS-1:0] dr;
  logic [COORD_BITS-1:0] dc;
  logic [DIST_W-1:0]     sum;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_next;
  logic [ROOT_W-1:0] root_next;

  assign full_a = (count_a == CNT_W'(MAX_POINTS));
  assign full_b = (count_b == CNT_W'(MAX_POINTS));
  assign we_a   = cmd.load && item.action == ACT_LOAD_A && !full_a;
  assign we_b   = cmd.load && item.action == ACT_LOAD_B && !full_b;
  assign wpt    = {item.point_row[COORD_BITS-1:0], item.point_col[COORD_BITS-1:0]};
  assign addr_a = we_a ? count_a[ADDR_W-1:0] : (dir ? j : i);
  assign addr_b = we_b ? count_b[ADDR_W-1:0] : (dir ? i : j);

  phd_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .addr  (addr_a),
    .wdata (wpt),
    .rdata (rd_a)
  );

  phd_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .addr  (addr_b),
    .wdata (wpt),
    .rdata (rd_b)
  );

  assign out_src = dir ? rd_b : rd_a;
  assign in_pt   = dir ? rd_a : rd_b;
  assign n1      = dir ? count_b : count_a;
  assign n2      = dir ? count_a : count_b;

  assign or_r = outer_pt[PT_W-1:COORD_BITS];
  assign or_c = outer_pt[COORD_BITS-1:0];
  assign ir_r = in_pt[PT_W-1:COORD_BITS];
  assign ir_c = in_pt[COORD_BITS-1:0];
  assign dr   = (or_r >= ir_r) ? or_r - ir_r : ir_r - or_r;
  assign dc   = (or_c >= ir_c) ? or_c - ir_c : ir_c - or_c;
  assign sum  = DIST_W'(sq_r) + DIST_W'(sq_c);

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  always_comb begin
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
      dropped <= 1'b0;
      dir     <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      v1 <= cmd.inner_issue;
      v2 <= v1;
      if (cmd.load) begin
        case (item.action)
          ACT_LOAD_A: begin
            if (full_a) begin
              dropped <= 1'b1;
            end else begin
              count_a <= count_a + CNT_W'(1);
            end
          end
          ACT_LOAD_B: begin
            if (full_b) begin
              dropped <= 1'b1;
            end else begin
              count_b <= count_b + CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.report) begin
        count_a <= '0;
        count_b <= '0;
        dropped <= 1'b0;
      end
      if (cmd.begin_run) begin
        dir <= 1'b0;
      end
      if (cmd.next_dir) begin
        dir <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_run) begin
      i     <= '0;
      worst <= '0;
    end
    if (cmd.finish_point) begin
      i <= i + ADDR_W'(1);
      if (best > worst) begin
        worst <= best;
      end
    end
    if (cmd.next_dir) begin
      i <= '0;
    end
    if (cmd.outer_latch) begin
      outer_pt <= out_src;
      j        <= '0;
      best     <= '1;
    end
    if (cmd.inner_issue) begin
      j <= j + ADDR_W'(1);
    end
    if (v1) begin
      sq_r <= SQD_W'(dr) * SQD_W'(dr);
      sq_c <= SQD_W'(dc) * SQD_W'(dc);
    end
    if (v2 && sum < best) begin
      best <= sum;
    end
    if (cmd.sqrt_start) begin
      rad  <= RAD_W'({worst, {(2 * FRAC_BITS){1'b0}}});
      rem  <= '0;
      root <= '0;
      step <= '0;
    end
    if (cmd.sqrt_step) begin
      rad  <= rad << 2;
      rem  <= rem_next;
      root <= root_next;
      step <= step + STEP_W'(1);
    end
  end

  assign stat.empty      = (count_a == '0) || (count_b == '0);
  assign stat.last_outer = (CNT_W'(i) == n1 - CNT_W'(1));
  assign stat.last_inner = (CNT_W'(j) == n2 - CNT_W'(1));
  assign stat.pipe_busy  = v1 || v2;
  assign stat.dir        = dir;
  assign stat.sqrt_last  = (step == STEP_W'(ROOT_W - 1));

  assign result.squared_distance = SQ_W'(worst);
  assign result.distance_q8      = Q8_W'(root);
  assign result.empty_set        = stat.empty;
  assign result.overflow         = dropped;

endmodule

>>> design/pixel_set_hausdorff_distance.sv
// Symmetric Hausdorff distance between two pixel sets. A load beat (action
// load A or load B) leaves busy low, so points can stream in one per
// cycle; a load into a full store is dropped and flagged. A compute beat
// raises busy until the result is given. The compute time is set by the
// inner search, which reads one point pair per cycle through the single
// read port of the inner point store, plus a bit-serial square root. The
// result is shown on result while done is high for exactly one cycle, in
// the last busy cycle; the receiver cannot stall it and must take it then.
// Both stores and the overflow flag are cleared after it.
module pixel_set_hausdorff_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  phd_pkg::in_item_t  item,
  output logic               busy,
  output logic               done,
  output phd_pkg::out_item_t result
);

  import phd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  phd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  phd_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

>>> design/phd_checker.sv
module phd_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input phd_pkg::in_item_t  item,
  input logic               busy,
  input logic               done,
  input phd_pkg::out_item_t result
);

  import phd_pkg::*;

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat outside a compute");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("compute gave more than one result beat");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.action != ACT_COMPUTE) |=> !busy && !done)
    else $error("load beat stalled the block");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.action == ACT_COMPUTE) |=> busy)
    else $error("compute beat did not start");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.empty_set) |->
      (result.squared_distance == '0 && result.distance_q8 == '0))
    else $error("empty set with nonzero distance");

endmodule

bind pixel_set_hausdorff_distance phd_checker u_phd_checker (.*);

>>> tb/pixel_set_hausdorff_distance_tb.sv
module pixel_set_hausdorff_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import phd_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PIX_MAX = (1 << FIELD_W) - 1;
  localparam logic [FIELD_W-1:0] COORD_MASK = FIELD_W'((1 << COORD_BITS) - 1);
  localparam int RAND_BEATS = 200;
  localparam int QUIET_BEATS = 50;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_SHOWN = 10;
  localparam int N_PLAN = 25;

  typedef struct packed {
    logic [FIELD_W-1:0] r;
    logic [FIELD_W-1:0] c;
  } pixel_t;

  typedef struct packed {
    logic [1:0]         act;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic               fixed;
    out_item_t          want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  item = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  pixel_t    set_a[$];
  pixel_t    set_b[$];
  bit        points_dropped = 1'b0;
  out_item_t pending_results[$];
  out_item_t want_res;

  bit idle_on = 1'b1;
  int fail_count = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int empty_seen = 0;
  int overflow_seen = 0;

  plan_row_t plan [N_PLAN] = '{
    '{ACT_COMPUTE, 10'd0,    10'd0,    1'b1, '{21'd0,       19'd0,      1'b1, 1'b0}},
    '{ACT_LOAD_A,  10'd0,    10'd0,    1'b0, '0},
    '{ACT_LOAD_B,  10'd1023, 10'd1023, 1'b0, '0},
    '{ACT_COMPUTE, 10'd1023, 10'd1023, 1'b1, '{21'd2093058, 19'd370365, 1'b0, 1'b0}},
    '{ACT_LOAD_A,  10'd1023, 10'd0,    1'b0, '0},
    '{ACT_UNUSED,  10'd1023, 10'd1023, 1'b0, '0},
    '{ACT_LOAD_B,  10'd1023, 10'd0,    1'b0, '0},
    '{ACT_COMPUTE, 10'd0,    10'd1023, 1'b1, '{21'd0,       19'd0,      1'b0, 1'b0}},
    '{ACT_LOAD_A,  10'd3,    10'd4,    1'b0, '0},
    '{ACT_LOAD_B,  10'd0,    10'd0,    1'b0, '0},
    '{ACT_COMPUTE, 10'd0,    10'd0,    1'b1, '{21'd25,      19'd1280,   1'b0, 1'b0}},
    '{ACT_LOAD_A,  10'd5,    10'd5,    1'b0, '0},
    '{ACT_COMPUTE, 10'd0,    10'd0,    1'b1, '{21'd0,       19'd0,      1'b1, 1'b0}},
    '{ACT_LOAD_B,  10'd7,    10'd9,    1'b0, '0},
    '{ACT_COMPUTE, 10'd0,    10'd0,    1'b1, '{21'd0,       19'd0,      1'b1, 1'b0}},
    '{ACT_LOAD_A,  10'd0,    10'd0,    1'b0, '0},
    '{ACT_LOAD_A,  10'd10,   10'd0,    1'b0, '0},
    '{ACT_LOAD_B,  10'd0,    10'd0,    1'b0, '0},
    '{ACT_LOAD_B,  10'd0,    10'd1023, 1'b0, '0},
    '{ACT_COMPUTE, 10'd512,  10'd256,  1'b0, '0},
    '{ACT_UNUSED,  10'd0,    10'd0,    1'b0, '0},
    '{ACT_LOAD_B,  10'd512,  10'd1,    1'b0, '0},
    '{ACT_LOAD_A,  10'd1,    10'd512,  1'b0, '0},
    '{ACT_LOAD_A,  10'd1,    10'd512,  1'b0, '0},
    '{ACT_COMPUTE, 10'd0,    10'd0,    1'b0, '0}
  };

  pixel_set_hausdorff_distance i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  function automatic longint sq_gap(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
    longint d;
    d = (p >= q) ? longint'(p - q) : longint'(q - p);
    return d * d;
  endfunction

  function automatic longint worst_nearest(pixel_t src[$], pixel_t dst[$]);
    longint worst;
    longint best;
    longint d;
    worst = 0;
    foreach (src[i]) begin
      best = -1;
      foreach (dst[j]) begin
        d = sq_gap(src[i].r, dst[j].r) + sq_gap(src[i].c, dst[j].c);
        if (best < 0 || d < best) best = d;
      end
      if (best > worst) worst = best;
    end
    return worst;
  endfunction

  function automatic longint root_q8(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = Q8_W; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic predict_beat(input in_item_t beat, output bit got, output out_item_t res);
    pixel_t p;
    longint ab;
    longint ba;
    longint sq;
    got = 1'b0;
    res = '0;
    p.r = beat.point_row & COORD_MASK;
    p.c = beat.point_col & COORD_MASK;
    case (beat.action)
      ACT_LOAD_A: begin
        if (set_a.size() < MAX_POINTS) set_a.push_back(p);
        else points_dropped = 1'b1;
      end
      ACT_LOAD_B: begin
        if (set_b.size() < MAX_POINTS) set_b.push_back(p);
        else points_dropped = 1'b1;
      end
      ACT_COMPUTE: begin
        got = 1'b1;
        if (set_a.size() == 0 || set_b.size() == 0) begin
          res.empty_set = 1'b1;
        end else begin
          ab = worst_nearest(set_a, set_b);
          ba = worst_nearest(set_b, set_a);
          sq = (ab > ba) ? ab : ba;
          res.squared_distance = sq[SQ_W-1:0];
          res.distance_q8 = Q8_W'(root_q8(sq << 16));
        end
        res.overflow = points_dropped;
        set_a.delete();
        set_b.delete();
        points_dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic drive_beat(input in_item_t beat, input bit use_fixed, input out_item_t fixed_want);
    bit got;
    out_item_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    item <= beat;
    do @(posedge clk); while (busy);
    predict_beat(beat, got, pred);
    if (got) pending_results.push_back(use_fixed ? fixed_want : pred);
    beats_sent++;
  endtask

  function automatic pixel_t make_pixel(int mode, pixel_t ctr);
    pixel_t p;
    case (mode)
      1, 3: begin
        p.r = ctr.r + FIELD_W'($urandom_range(0, 31));
        p.c = ctr.c + FIELD_W'($urandom_range(0, 31));
      end
      2: begin
        p.r = FIELD_W'($urandom_range(0, 1) ? PIX_MAX - $urandom_range(0, 2)
                                            : $urandom_range(0, 2));
        p.c = FIELD_W'($urandom_range(0, 1) ? PIX_MAX - $urandom_range(0, 2)
                                            : $urandom_range(0, 2));
      end
      default: begin
        p.r = FIELD_W'($urandom_range(0, PIX_MAX));
        p.c = FIELD_W'($urandom_range(0, PIX_MAX));
      end
    endcase
    return p;
  endfunction

  function automatic int pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel <= 2) return $urandom_range(9, 24);
    return $urandom_range(1, 8);
  endfunction

  task automatic fill_store(input action_t which, input int n);
    in_item_t b;
    for (int k = 0; k < n; k++) begin
      b.action = which;
      b.point_row = FIELD_W'($urandom);
      b.point_col = FIELD_W'($urandom);
      drive_beat(b, 1'b0, '0);
    end
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= MAX_SHOWN)
      $display("%0t: %s differs, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (result.empty_set) empty_seen++;
      if (result.overflow) overflow_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("%0t: result beat with none outstanding, squared_distance %0d",
                   $realtime, result.squared_distance);
      end else begin
        want_res = pending_results.pop_front();
        if (result.squared_distance !== want_res.squared_distance)
          note_mismatch("squared_distance", want_res.squared_distance, result.squared_distance);
        if (result.distance_q8 !== want_res.distance_q8)
          note_mismatch("distance_q8", want_res.distance_q8, result.distance_q8);
        if (result.empty_set !== want_res.empty_set)
          note_mismatch("empty_set", want_res.empty_set, result.empty_set);
        if (result.overflow !== want_res.overflow)
          note_mismatch("overflow", want_res.overflow, result.overflow);
      end
    end
  end

  initial begin
    #3ms;
    $display("pixel_set_hausdorff_distance: mismatch");
    $finish;
  end

  initial begin
    in_item_t b;
    pixel_t   ctr;
    pixel_t   px;
    int       rand_beats;
    int       need_a;
    int       need_b;
    int       mode;
    bit       to_a;

    rand_beats = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      b.action = action_t'(plan[i].act);
      b.point_row = plan[i].row;
      b.point_col = plan[i].col;
      drive_beat(b, plan[i].fixed, plan[i].want);
    end

    fill_store(ACT_LOAD_A, MAX_POINTS + 1);
    fill_store(ACT_LOAD_B, 1);
    b.action = ACT_COMPUTE;
    b.point_row = FIELD_W'($urandom);
    b.point_col = FIELD_W'($urandom);
    drive_beat(b, 1'b0, '0);

    while (rand_beats < RAND_BEATS) begin
      idle_on = (rand_beats < RAND_BEATS - QUIET_BEATS) && ($urandom_range(0, 3) != 0);
      need_a = pick_size();
      need_b = pick_size();
      mode = $urandom_range(0, 3);
      ctr.r = FIELD_W'($urandom);
      ctr.c = FIELD_W'($urandom);
      while (need_a + need_b > 0) begin
        if ($urandom_range(0, 19) == 0) begin
          b.action = action_t'(ACT_UNUSED);
          b.point_row = FIELD_W'($urandom);
          b.point_col = FIELD_W'($urandom);
          drive_beat(b, 1'b0, '0);
        end
        to_a = (need_b == 0) || (need_a != 0 && $urandom_range(0, 1) == 1);
        px = make_pixel(mode, ctr);
        b.action = to_a ? ACT_LOAD_A : ACT_LOAD_B;
        b.point_row = px.r;
        b.point_col = px.c;
        drive_beat(b, 1'b0, '0);
        if (to_a) need_a--;
        else need_b--;
        rand_beats++;
      end
      if ($urandom_range(0, 9) != 0) begin
        b.action = ACT_COMPUTE;
        b.point_row = FIELD_W'($urandom);
        b.point_col = FIELD_W'($urandom);
        drive_beat(b, 1'b0, '0);
        rand_beats++;
      end
    end
    b.action = ACT_COMPUTE;
    drive_beat(b, 1'b0, '0);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d beats driven, %0d distance results checked", beats_sent, results_seen);
    $display("%0d results flagged an empty set, %0d flagged dropped points",
             empty_seen, overflow_seen);
    if (fail_count == 0) begin
      $display("pixel_set_hausdorff_distance: match");
    end else begin
      $display("pixel_set_hausdorff_distance: mismatch");
    end
    $finish;
  end

endmodule
